[hw/rtl/tatan2_pkg.sv]
// Shared types, widths, constants and the arctangent table for the table_atan2 core.
package tatan2_pkg;

	localparam int SAMPLE_WIDTH  = 16;
	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int ROM_IDX_W     = $clog2(TABLE_ENTRIES + 1);
	localparam int FRAC_W        = 16;
	localparam int Q_W           = FRAC_W + 1;
	localparam int MAG_W         = SAMPLE_WIDTH;
	localparam int REM_W         = MAG_W + 1;
	localparam int ROM_W         = 16;
	localparam int PROD_W        = ROM_W + Q_W;
	localparam int A_W           = 18;
	localparam int ANGLE_W       = 16;
	localparam int IN_W          = 2 * SAMPLE_WIDTH;

	localparam logic [A_W-1:0] PI_HALF_Q16 = A_W'(102944);
	localparam logic [A_W-1:0] PI_Q16      = A_W'(205887);
	localparam int ANGLE_MAX    = 25736;
	localparam int ROM_STEP_MAX = (1 << FRAC_W) / TABLE_ENTRIES + 1;

	localparam int Q30          = 30;
	localparam int SERIES_TERMS = 24;
	localparam int DIV_BITS     = 40;

	typedef struct packed {
		logic zero;
		logic steep;
		logic x_neg;
		logic y_neg;
	} tatan2_side_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [MAG_W-1:0] dvs;
		logic [Q_W-1:0]   quo;
		tatan2_side_t     side;
	} tatan2_cell_t;

	typedef logic [ROM_W-1:0] tatan2_rom_t [TABLE_ENTRIES+1];

	// shift-subtract long division, elaboration only
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		int i;
		q = '0;
		r = '0;
		for (i = DIV_BITS - 1; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(num/den) in Q0.30, Taylor series, num < den
	function automatic logic signed [63:0] series_atan(logic [63:0] num, logic [63:0] den);
		logic [63:0] w;
		logic [63:0] w2;
		logic [63:0] term;
		logic [63:0] q;
		logic signed [63:0] sum;
		int n;
		w = udiv64(num << Q30, den);
		w2 = (w * w) >> Q30;
		term = w;
		sum = '0;
		for (n = 0; n < SERIES_TERMS; n++) begin
			q = udiv64(term, 64'(2 * n + 1));
			if (n[0])
				sum = sum - signed'(q);
			else
				sum = sum + signed'(q);
			term = (term * w2) >> Q30;
		end
		return sum;
	endfunction

	function automatic tatan2_rom_t build_rom();
		tatan2_rom_t rom;
		logic signed [63:0] quarter;
		logic signed [63:0] v;
		logic [63:0] nn;
		int k;
		quarter = 4 * series_atan(64'd1, 64'd5) - series_atan(64'd1, 64'd239);
		nn = 64'(TABLE_ENTRIES);
		for (k = 0; k <= TABLE_ENTRIES; k++) begin
			if (2 * k <= TABLE_ENTRIES)
				v = series_atan(64'(k), nn);
			else
				v = quarter - series_atan(nn - 64'(k), nn + 64'(k));
			if (v < 0)
				v = '0;
			rom[k] = ROM_W'((unsigned'(v) + 64'(1 << 13)) >> 14);
		end
		return rom;
	endfunction

	localparam tatan2_rom_t ATAN_ROM = build_rom();

endpackage

[hw/rtl/tatan2_div_cell.sv]
// One restoring-division cell: resolves one quotient bit and passes the remainder on.
module tatan2_div_cell import tatan2_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_vld,
	input  tatan2_cell_t in_cell,
	output logic         out_vld,
	output tatan2_cell_t out_cell
);

	logic             ge;
	logic [REM_W-1:0] dvs_ext;
	logic [REM_W-1:0] rem_sub;
	logic             vld_s1;
	tatan2_cell_t     cell_s1;

	assign dvs_ext = REM_W'(in_cell.dvs);
	assign ge      = in_cell.rem >= dvs_ext;
	assign rem_sub = ge ? (in_cell.rem - dvs_ext) : in_cell.rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_s1.rem  <= {rem_sub[REM_W-2:0], 1'b0};
			cell_s1.dvs  <= in_cell.dvs;
			cell_s1.quo  <= {in_cell.quo[Q_W-2:0], ge};
			cell_s1.side <= in_cell.side;
		end
	end

	assign out_vld  = vld_s1;
	assign out_cell = cell_s1;

	// partial remainder stays below twice the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_vld && in_cell.dvs != '0) |=> (out_cell.rem < {out_cell.dvs, 1'b0}))
		else $error("remainder out of range");

endmodule

[hw/rtl/tatan2_interp.sv]
// Table lookup, linear interpolation and octant unfolding of the ratio.
module tatan2_interp import tatan2_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [Q_W-1:0]     in_quo,
	input  tatan2_side_t       in_side,
	output logic               res_vld,
	output logic [ANGLE_W-1:0] res_angle
);

	logic [IDX_W:0]     idx_raw;
	logic               clamp;
	logic [IDX_W-1:0]   idx;
	logic [Q_W-1:0]     frac;
	logic [ROM_W-1:0]   rom_lo;
	logic [ROM_W-1:0]   rom_hi;

	logic               vld_s1;
	logic [ROM_W-1:0]   r0_s1;
	logic [ROM_W-1:0]   diff_s1;
	logic [Q_W-1:0]     frac_s1;
	tatan2_side_t       side_s1;

	logic               vld_s2;
	logic [ROM_W-1:0]   r0_s2;
	logic [PROD_W-1:0]  prod_s2;
	tatan2_side_t       side_s2;

	logic [A_W-1:0]     base;
	logic [A_W-1:0]     oct;
	logic [A_W-1:0]     ang;
	logic [A_W-1:0]     rnd;
	logic [ANGLE_W-1:0] mag;

	assign idx_raw = in_quo[Q_W-1:FRAC_W-IDX_W];
	assign clamp   = idx_raw[IDX_W];
	assign idx     = clamp ? {IDX_W{1'b1}} : idx_raw[IDX_W-1:0];
	assign frac    = clamp ? (Q_W'(1) << FRAC_W)
	                       : {1'b0, in_quo[FRAC_W-IDX_W-1:0], {IDX_W{1'b0}}};
	assign rom_lo  = ATAN_ROM[ROM_IDX_W'(idx)];
	assign rom_hi  = ATAN_ROM[ROM_IDX_W'(idx) + ROM_IDX_W'(1)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r0_s1   <= rom_lo;
			diff_s1 <= rom_hi - rom_lo;
			frac_s1 <= frac;
			side_s1 <= in_side;
			r0_s2   <= r0_s1;
			prod_s2 <= PROD_W'(diff_s1) * PROD_W'(frac_s1);
			side_s2 <= side_s1;
		end
	end

	assign base = A_W'(r0_s2) + A_W'(prod_s2[PROD_W-1:FRAC_W]);
	assign oct  = side_s2.steep ? (PI_HALF_Q16 - base) : base;
	assign ang  = side_s2.x_neg ? (PI_Q16 - oct) : oct;
	assign rnd  = ang + A_W'(4);
	assign mag  = ANGLE_W'(rnd >> 3);

	always_comb begin
		if (side_s2.zero)
			res_angle = '0;
		else if (side_s2.y_neg)
			res_angle = ANGLE_W'(0) - mag;
		else
			res_angle = mag;
	end

	assign res_vld = vld_s2;

	// table is monotonic with bounded steps
	a_rom_step: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (32'(diff_s1) <= 32'(ROM_STEP_MAX)))
		else $error("table step out of range");

endmodule

[hw/rtl/table_atan2_core.sv]
// Top level of the table_atan2 core: fold, division cell chain, interpolation, output skid.
//
//  channel | dir | tdata fields (low bit up)          | tuser | tlast
//  s_      | in  | x_value[15:0], y_value[31:16]      | -     | -
//  m_      | out | angle[15:0] (signed Q3.13)         | -     | -
//
// One beat per cycle sustained while s_tready is high. Path: fold stage, one cell per
// quotient bit for 17 bits, table read, multiply, then the output register.
// Reset clears only valid flags; the table is constant, no clearing pass.
// A stalled result waits in the output register while one more beat may land in the
// skid register; s_tready drops only while the skid register is full.
module table_atan2_core import tatan2_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // x_value, y_value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ANGLE_W-1:0] m_tdata    // angle
);

	logic                      en;
	logic signed [MAG_W-1:0]   x_in;
	logic signed [MAG_W-1:0]   y_in;
	logic [MAG_W-1:0]          ax;
	logic [MAG_W-1:0]          ay;
	logic                      steep;
	tatan2_cell_t              prep;

	logic                      prep_vld_s1;
	tatan2_cell_t              prep_s1;

	logic                      chain_vld  [Q_W+1];
	tatan2_cell_t              chain_cell [Q_W+1];

	logic                      res_vld;
	logic [ANGLE_W-1:0]        res_angle;

	logic                      out_vld_q;
	logic [ANGLE_W-1:0]        out_data_q;
	logic                      skid_vld_q;
	logic [ANGLE_W-1:0]        skid_data_q;
	logic                      load_out;
	logic                      load_skid;

	assign en       = !skid_vld_q;
	assign s_tready = en;

	assign x_in  = s_tdata[SAMPLE_WIDTH-1:0];
	assign y_in  = s_tdata[IN_W-1:SAMPLE_WIDTH];
	assign ax    = x_in[MAG_W-1] ? MAG_W'(-x_in) : MAG_W'(x_in);
	assign ay    = y_in[MAG_W-1] ? MAG_W'(-y_in) : MAG_W'(y_in);
	assign steep = ay > ax;

	always_comb begin
		prep.rem        = REM_W'(steep ? ax : ay);
		prep.dvs        = steep ? ay : ax;
		prep.quo        = '0;
		prep.side.zero  = (x_in == '0) && (y_in == '0);
		prep.side.steep = steep;
		prep.side.x_neg = x_in[MAG_W-1];
		prep.side.y_neg = y_in[MAG_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_vld_s1 <= 1'b0;
		end else if (en) begin
			prep_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1 <= prep;
		end
	end

	assign chain_vld[0]  = prep_vld_s1;
	assign chain_cell[0] = prep_s1;

	for (genvar g = 0; g < Q_W; g++) begin : g_cell
		tatan2_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (chain_vld[g]),
			.in_cell  (chain_cell[g]),
			.out_vld  (chain_vld[g+1]),
			.out_cell (chain_cell[g+1])
		);
	end

	tatan2_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (chain_vld[Q_W]),
		.in_quo    (chain_cell[Q_W].quo),
		.in_side   (chain_cell[Q_W].side),
		.res_vld   (res_vld),
		.res_angle (res_angle)
	);

	assign load_out  = (skid_vld_q && m_tready) ||
	                   (!skid_vld_q && res_vld && (!out_vld_q || m_tready));
	assign load_skid = !skid_vld_q && res_vld && out_vld_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (load_out)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
			if (load_skid)
				skid_vld_q <= 1'b1;
			else if (m_tready)
				skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_data_q <= skid_vld_q ? skid_data_q : res_angle;
		if (load_skid)
			skid_data_q <= res_angle;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a beat while output is empty");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ($signed(out_data_q) <= $signed(ANGLE_W'(ANGLE_MAX)) &&
		               $signed(out_data_q) >= -$signed(ANGLE_W'(ANGLE_MAX))))
		else $error("angle beyond pi");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && !m_tready) |=> ($stable(skid_data_q) && skid_vld_q))
		else $error("waiting skid beat lost");

endmodule
